// ===== rtl/i2cm_pkg.sv =====
// i2cm_pkg: shared codes, widths, types and phase decode functions for the i2c master
// used by the interfaces, the core, the register block and the top level
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int STEP_W    = 6;
    localparam int CNT_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // command codes
    localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
    localparam logic [OP_W-1:0] OP_START     = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTART   = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_ACK  = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_NACK = 3'd6;

    // register indexes
    localparam logic REG_PHASE_TICKS = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [CNT_W-1:0] PHASE_TICKS_RST = 16'd500;
    localparam logic [CNT_W-1:0] ACK_TIMEOUT_RST = 16'd2000;

    // write sequence landmarks
    localparam logic [STEP_W-1:0] WR_BITS_END   = 6'd24;
    localparam logic [STEP_W-1:0] WR_ACK_LOW    = 6'd25;
    localparam logic [STEP_W-1:0] WR_ACK_REL    = 6'd26;
    localparam logic [STEP_W-1:0] WR_ACK_HIGH   = 6'd27;
    localparam logic [STEP_W-1:0] WR_POLL_STEP  = 6'd28;
    localparam logic [STEP_W-1:0] WR_DONE_STEP  = 6'd29;
    localparam logic [STEP_W-1:0] WR_ABORT_STEP = 6'd30;
    localparam logic [STEP_W-1:0] WR_STOP_HIGH  = 6'd31;
    localparam logic [STEP_W-1:0] WR_LAST_STEP  = 6'd32;

    // read sequence landmarks
    localparam logic [STEP_W-1:0] RD_FIRST_BIT  = 6'd1;
    localparam logic [STEP_W-1:0] RD_LAST_BIT   = 6'd15;
    localparam logic [STEP_W-1:0] RD_BITS_END   = 6'd16;
    localparam logic [STEP_W-1:0] RD_ACK_LOW    = 6'd17;
    localparam logic [STEP_W-1:0] RD_ACK_DRIVE  = 6'd18;
    localparam logic [STEP_W-1:0] RD_ACK_HIGH   = 6'd19;
    localparam logic [STEP_W-1:0] RD_LAST_STEP  = 6'd20;

    // start and stop landmarks
    localparam logic [STEP_W-1:0] ST_LAST_STEP  = 6'd3;
    localparam logic [STEP_W-1:0] SP_LAST_STEP  = 6'd2;

    // slot of a write bit step inside its three-phase group
    localparam logic [1:0] SLOT_CLK_LOW  = 2'd0;
    localparam logic [1:0] SLOT_DATA     = 2'd1;
    localparam logic [1:0] SLOT_CLK_HIGH = 2'd2;

    typedef struct packed {
        logic scl;
        logic sda;
    } t_lines;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_seen;
        logic              timed_out;
    } t_result;

    // position of a write bit step within its group (steps below 24 only)
    function automatic logic [1:0] wr_slot(input logic [STEP_W-1:0] step);
        logic [1:0] slot;
        case (step)
            6'd0, 6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21: begin
                slot = SLOT_CLK_LOW;
            end
            6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22: begin
                slot = SLOT_DATA;
            end
            default: begin
                slot = SLOT_CLK_HIGH;
            end
        endcase
        return slot;
    endfunction

    // line levels after entering a phase
    function automatic t_lines enter_phase(input logic [OP_W-1:0]   cmd,
                                           input logic [STEP_W-1:0] step,
                                           input logic              bit_msb,
                                           input t_lines            cur);
        t_lines nxt;
        nxt = cur;
        case (cmd)
            OP_START, OP_RESTART: begin
                case (step)
                    6'd0:    nxt.scl = 1'b1;
                    6'd1:    nxt.sda = 1'b1;
                    6'd2:    nxt.sda = 1'b0;
                    default: nxt.scl = 1'b0;
                endcase
            end
            OP_STOP: begin
                case (step)
                    6'd0:    nxt.sda = 1'b0;
                    6'd1:    nxt.scl = 1'b1;
                    default: nxt.sda = 1'b1;
                endcase
            end
            OP_WRITE: begin
                if (step < WR_BITS_END) begin
                    case (wr_slot(step))
                        SLOT_CLK_LOW: nxt.scl = 1'b0;
                        SLOT_DATA:    nxt.sda = bit_msb;
                        default:      nxt.scl = 1'b1;
                    endcase
                end else if (step == WR_BITS_END || step == WR_ACK_LOW ||
                             step == WR_DONE_STEP) begin
                    nxt.scl = 1'b0;
                end else if (step == WR_ACK_REL || step == WR_LAST_STEP) begin
                    nxt.sda = 1'b1;
                end else if (step == WR_ACK_HIGH || step == WR_STOP_HIGH) begin
                    nxt.scl = 1'b1;
                end else if (step == WR_ABORT_STEP) begin
                    nxt.sda = 1'b0;
                end
            end
            OP_READ_ACK, OP_READ_NACK: begin
                if (step == 6'd0 || step == RD_ACK_LOW || step == RD_LAST_STEP) begin
                    nxt.scl = 1'b0;
                end else if (step <= RD_BITS_END) begin
                    if (step[0]) begin
                        nxt.scl = 1'b1;
                        if (step == RD_FIRST_BIT) begin
                            nxt.sda = 1'b1;
                        end
                    end else begin
                        nxt.scl = 1'b0;
                    end
                end else if (step == RD_ACK_DRIVE) begin
                    nxt.sda = (cmd == OP_READ_NACK);
                end else if (step == RD_ACK_HIGH) begin
                    nxt.scl = 1'b1;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

    // true when the phase is the final one of its command
    function automatic logic is_last_phase(input logic [OP_W-1:0]   cmd,
                                           input logic [STEP_W-1:0] step);
        logic last;
        case (cmd)
            OP_START, OP_RESTART:      last = (step >= ST_LAST_STEP);
            OP_STOP:                   last = (step >= SP_LAST_STEP);
            OP_WRITE:                  last = (step == WR_DONE_STEP) ||
                                              (step >= WR_LAST_STEP);
            OP_READ_ACK, OP_READ_NACK: last = (step >= RD_LAST_STEP);
            default:                   last = 1'b1;
        endcase
        return last;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cm_if.sv =====
// i2cm_if: valid/ready channel interfaces for command words and result words
// depends on i2cm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_cmd_if import i2cm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;

    modport source (output valid, op, write_data, sda_in, input ready);
    modport sink   (input valid, op, write_data, sda_in, output ready);
endinterface

interface i2cm_res_if import i2cm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ack_seen;
    logic              timed_out;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_seen, timed_out, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_seen, timed_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cm_cfg_regs.sv =====
// i2cm_cfg_regs: apb register block holding phase length and acknowledge timeout
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_cfg_regs import i2cm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CNT_W-1:0]      o_phase_ticks,
    output logic      [CNT_W-1:0]      o_ack_timeout
);

    logic             w_wr;
    logic             w_sel;
    logic [CNT_W-1:0] r_phase_ticks;
    logic [CNT_W-1:0] r_ack_timeout;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_sel  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (w_wr) begin
            if (w_sel == REG_PHASE_TICKS) begin
                r_phase_ticks <= pwdata[CNT_W-1:0];
            end else begin
                r_ack_timeout <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (w_sel == REG_ACK_TIMEOUT) begin
            prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, r_ack_timeout};
        end else begin
            prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, r_phase_ticks};
        end
    end

    assign o_phase_ticks = r_phase_ticks;
    assign o_ack_timeout = r_ack_timeout;

endmodule

`default_nettype wire

// ===== rtl/i2cm_core.sv =====
// i2cm_core: bus phase sequencer state and its one-tick next-state logic
// depends on i2cm_pkg for codes, phase decode and the result struct
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core import i2cm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tick,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [BYTE_W-1:0] i_write_data,
    input  wire logic              i_sda_in,
    input  wire logic [CNT_W-1:0]  i_phase_ticks,
    input  wire logic [CNT_W-1:0]  i_ack_timeout,
    output t_result                o_result
);

    logic [OP_W-1:0]   r_cmd,       n_cmd;
    logic [STEP_W-1:0] r_step,      n_step;
    logic [CNT_W-1:0]  r_phase_cnt, n_phase_cnt;
    logic [CNT_W-1:0]  r_ack_cnt,   n_ack_cnt;
    logic [BYTE_W-1:0] r_shift,     n_shift;
    logic [BYTE_W-1:0] r_read_byte, n_read_byte;
    t_lines            r_lines,     n_lines;
    logic              r_ack,       n_ack;
    logic              r_timeout,   n_timeout;

    always_comb begin
        logic              start;
        logic [OP_W-1:0]   cmd0;
        logic [STEP_W-1:0] step0;
        logic [STEP_W-1:0] step_inc;
        logic [CNT_W-1:0]  pc0;
        logic [CNT_W-1:0]  pc_inc;
        logic [CNT_W-1:0]  ticks;
        logic [BYTE_W-1:0] sb0;
        logic [BYTE_W-1:0] sb_end;
        t_lines            lines0;
        logic              done;

        ticks  = (i_phase_ticks == '0) ? CNT_W'(1) : i_phase_ticks;
        start  = (r_cmd == OP_NONE) && (i_op >= OP_START) && (i_op <= OP_READ_NACK);

        // command launch happens before the tick is processed
        cmd0   = r_cmd;
        step0  = r_step;
        pc0    = r_phase_cnt;
        sb0    = r_shift;
        lines0 = r_lines;
        n_ack_cnt = r_ack_cnt;
        if (start) begin
            cmd0      = i_op;
            step0     = '0;
            pc0       = '0;
            n_ack_cnt = '0;
            sb0       = (i_op == OP_WRITE) ? i_write_data : '0;
            lines0    = enter_phase(i_op, '0, sb0[BYTE_W-1], r_lines);
        end

        n_cmd       = cmd0;
        n_step      = step0;
        n_phase_cnt = pc0;
        n_shift     = sb0;
        n_lines     = lines0;
        n_read_byte = r_read_byte;
        n_ack       = r_ack;
        n_timeout   = r_timeout;
        done        = 1'b0;
        step_inc    = step0 + STEP_W'(1);
        pc_inc      = pc0 + CNT_W'(1);
        sb_end      = sb0;

        if (cmd0 != OP_NONE) begin
            if (cmd0 == OP_WRITE && step0 == WR_POLL_STEP) begin
                // acknowledge poll, one sample per tick
                if (!i_sda_in) begin
                    n_ack       = 1'b1;
                    n_timeout   = 1'b0;
                    n_step      = WR_DONE_STEP;
                    n_phase_cnt = '0;
                    n_lines     = enter_phase(cmd0, WR_DONE_STEP, sb0[BYTE_W-1], lines0);
                end else if (r_ack_cnt >= i_ack_timeout) begin
                    n_ack       = 1'b0;
                    n_timeout   = 1'b1;
                    n_step      = WR_ABORT_STEP;
                    n_phase_cnt = '0;
                    n_lines     = enter_phase(cmd0, WR_ABORT_STEP, sb0[BYTE_W-1], lines0);
                end else begin
                    n_ack_cnt = r_ack_cnt + CNT_W'(1);
                end
            end else if (pc_inc >= ticks) begin
                n_phase_cnt = '0;
                if (cmd0 == OP_WRITE && step0 < WR_BITS_END &&
                    wr_slot(step0) == SLOT_DATA) begin
                    sb_end = {sb0[BYTE_W-2:0], 1'b0};
                end else if ((cmd0 == OP_READ_ACK || cmd0 == OP_READ_NACK) &&
                             step0 >= RD_FIRST_BIT && step0 <= RD_LAST_BIT && step0[0]) begin
                    sb_end = {sb0[BYTE_W-2:0], i_sda_in};
                    if (step0 == RD_LAST_BIT) begin
                        n_read_byte = sb_end;
                    end
                end
                n_shift = sb_end;
                if (is_last_phase(cmd0, step0)) begin
                    done   = 1'b1;
                    n_cmd  = OP_NONE;
                    n_step = '0;
                end else begin
                    n_step  = step_inc;
                    n_lines = enter_phase(cmd0, step_inc, sb_end[BYTE_W-1], lines0);
                    if (cmd0 == OP_WRITE && step_inc == WR_POLL_STEP) begin
                        n_ack_cnt = '0;
                    end
                end
            end else begin
                n_phase_cnt = pc_inc;
            end
        end

        o_result.scl_out   = lines0.scl;
        o_result.sda_out   = lines0.sda;
        o_result.busy_res  = (cmd0 != OP_NONE);
        o_result.done_res  = done;
        o_result.read_data = n_read_byte;
        o_result.ack_seen  = n_ack;
        o_result.timed_out = n_timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= OP_NONE;
            r_step      <= '0;
            r_phase_cnt <= '0;
            r_ack_cnt   <= '0;
            r_shift     <= '0;
            r_read_byte <= '0;
            r_lines     <= '{scl: 1'b1, sda: 1'b1};
            r_ack       <= 1'b0;
            r_timeout   <= 1'b0;
        end else if (i_tick) begin
            r_cmd       <= n_cmd;
            r_step      <= n_step;
            r_phase_cnt <= n_phase_cnt;
            r_ack_cnt   <= n_ack_cnt;
            r_shift     <= n_shift;
            r_read_byte <= n_read_byte;
            r_lines     <= n_lines;
            r_ack       <= n_ack;
            r_timeout   <= n_timeout;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bus_sequencer.sv =====
// i2c_master_bus_sequencer: top level of the pin-level i2c master
// depends on i2cm_pkg, i2cm_if, i2cm_cfg_regs and i2cm_core
`timescale 1ns / 1ps
`default_nettype none

// Pin-level i2c master. Every command-channel word is one tick of bus time and
// yields exactly one result word carrying the scl/sda drive levels for that tick,
// busy/done flags, the last read byte and the last acknowledge status. A command
// (start, restart, stop, write byte, read with ack, read with nack) is taken only
// while the sequencer is idle; otherwise it is ignored. Each bus phase lasts
// phase_ticks words (register 0 at byte address 0, zero acts as one), and the
// acknowledge wait after a write aborts with a stop once more than ack_timeout
// high samples are seen (register 1 at byte address 4). Throughput is one word
// per clock: the phase sequencer's next state is a single 16-bit count-and-compare
// plus phase decode, computed in the cycle a word is accepted, and the result is
// captured in an output register. A new word is accepted while the result register
// is empty or being drained in the same cycle, so a stalled sink holds off the source.

module i2c_master_bus_sequencer import i2cm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    i2cm_cmd_if.sink                   i_cmd,
    i2cm_res_if.source                 o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [CNT_W-1:0] w_phase_ticks;
    logic [CNT_W-1:0] w_ack_timeout;
    logic             w_accept;
    t_result          w_result;
    t_result          r_res;
    logic             r_res_valid;

    // configuration registers
    i2cm_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_phase_ticks (w_phase_ticks),
        .o_ack_timeout (w_ack_timeout)
    );

    // accept when the result register is free or drains this cycle
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // sequencer state advances by one tick per accepted word
    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (w_accept),
        .i_op          (i_cmd.op),
        .i_write_data  (i_cmd.write_data),
        .i_sda_in      (i_cmd.sda_in),
        .i_phase_ticks (w_phase_ticks),
        .i_ack_timeout (w_ack_timeout),
        .o_result      (w_result)
    );

    // result register, valid is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_result;
        end
    end

    assign o_res.valid     = r_res_valid;
    assign o_res.scl_out   = r_res.scl_out;
    assign o_res.sda_out   = r_res.sda_out;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.read_data = r_res.read_data;
    assign o_res.ack_seen  = r_res.ack_seen;
    assign o_res.timed_out = r_res.timed_out;

endmodule

`default_nettype wire
